/* src/rne_pkg.sv */
// Shared types, letter codes and the numeral table of the Roman numeral encoder.
package rne_pkg;

    localparam int unsigned VALUE_W  = 14;
    localparam int unsigned LETTER_W = 7;
    localparam int unsigned REM_W    = 12;
    localparam int unsigned AMOUNT_W = 10;
    localparam int unsigned INDEX_W  = 4;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 14'd4000;

    localparam logic [LETTER_W-1:0] LETTER_NONE = 7'd0;
    localparam logic [LETTER_W-1:0] LETTER_M    = 7'd77;
    localparam logic [LETTER_W-1:0] LETTER_D    = 7'd68;
    localparam logic [LETTER_W-1:0] LETTER_C    = 7'd67;
    localparam logic [LETTER_W-1:0] LETTER_L    = 7'd76;
    localparam logic [LETTER_W-1:0] LETTER_X    = 7'd88;
    localparam logic [LETTER_W-1:0] LETTER_V    = 7'd86;
    localparam logic [LETTER_W-1:0] LETTER_I    = 7'd73;

    typedef struct packed {
        logic [AMOUNT_W-1:0] amount;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                pair;
    } rne_entry_t;

    // Greedy table, largest amount first; subtractive pairs emit two letters.
    function automatic rne_entry_t rne_entry(input logic [INDEX_W-1:0] idx);
        rne_entry_t e;
        case (idx)
            4'd0:    e = '{10'd1000, LETTER_M, LETTER_M, 1'b0};
            4'd1:    e = '{10'd900,  LETTER_C, LETTER_M, 1'b1};
            4'd2:    e = '{10'd500,  LETTER_D, LETTER_D, 1'b0};
            4'd3:    e = '{10'd400,  LETTER_C, LETTER_D, 1'b1};
            4'd4:    e = '{10'd100,  LETTER_C, LETTER_C, 1'b0};
            4'd5:    e = '{10'd90,   LETTER_X, LETTER_C, 1'b1};
            4'd6:    e = '{10'd50,   LETTER_L, LETTER_L, 1'b0};
            4'd7:    e = '{10'd40,   LETTER_X, LETTER_L, 1'b1};
            4'd8:    e = '{10'd10,   LETTER_X, LETTER_X, 1'b0};
            4'd9:    e = '{10'd9,    LETTER_I, LETTER_X, 1'b1};
            4'd10:   e = '{10'd5,    LETTER_V, LETTER_V, 1'b0};
            4'd11:   e = '{10'd4,    LETTER_I, LETTER_V, 1'b1};
            default: e = '{10'd1,    LETTER_I, LETTER_I, 1'b0};
        endcase
        return e;
    endfunction

endpackage

/* src/roman_numeral_encoder.sv */
// Top level of the Roman numeral encoder: sequencer, shared subtractor and result register.
// One number is taken per request and its Roman numeral comes out one ASCII letter per
// result, the final letter flagged by last. Zero gives no result at all; a value of 4000
// or more gives a single result with error and last set and a letter of zero. The
// conversion walks a thirteen-entry table of amounts through a single compare-and-subtract
// unit: each cycle either emits one letter, unless the result side stalls, or moves on
// to the next entry. A new number is taken once the last letter sits in the result
// register, so that register may still be waiting on the far side.
module roman_numeral_encoder
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [rne_pkg::VALUE_W-1:0]   value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [rne_pkg::LETTER_W-1:0]  letter,
    output logic                          last,
    output logic                          error
);
    import rne_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t                state_reg, state_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [INDEX_W-1:0]    idx_reg, idx_next;
    logic                  phase_reg, phase_next;
    logic                  err_reg, err_next;
    logic                  valid_reg, valid_next;
    logic [LETTER_W-1:0]   letter_reg, letter_next;
    logic                  last_reg, last_next;
    logic                  error_reg, error_next;

    rne_entry_t            entry;
    logic [REM_W-1:0]      amount_ext;
    logic [REM_W-1:0]      diff;
    logic                  fits;
    logic                  load_ok;
    logic                  accept;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = valid_reg;
    assign letter       = letter_reg;
    assign last         = last_reg;
    assign error        = error_reg;

    assign entry      = rne_entry(idx_reg);
    assign amount_ext = {{(REM_W-AMOUNT_W){1'b0}}, entry.amount};
    assign diff       = rem_reg - amount_ext;
    assign fits       = (rem_reg >= amount_ext);
    assign load_ok    = !valid_reg || !result_stall;

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        err_next    = err_reg;
        valid_next  = valid_reg && result_stall;
        letter_next = letter_reg;
        last_next   = last_reg;
        error_next  = error_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                    rem_next   = value[REM_W-1:0];
                    idx_next   = '0;
                    phase_next = 1'b0;
                    err_next   = (value >= VALUE_LIMIT);
                end
            end
            ST_BUSY:
            begin
                if (err_reg)
                begin
                    if (load_ok)
                    begin
                        valid_next  = 1'b1;
                        letter_next = LETTER_NONE;
                        last_next   = 1'b1;
                        error_next  = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else if (rem_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (fits)
                begin
                    if (load_ok)
                    begin
                        valid_next = 1'b1;
                        error_next = 1'b0;
                        if (entry.pair && !phase_reg)
                        begin
                            letter_next = entry.first;
                            last_next   = 1'b0;
                            phase_next  = 1'b1;
                        end
                        else
                        begin
                            letter_next = entry.pair ? entry.second : entry.first;
                            last_next   = (diff == '0);
                            phase_next  = 1'b0;
                            rem_next    = diff;
                            if (diff == '0)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rem_reg    <= '0;
            idx_reg    <= '0;
            phase_reg  <= 1'b0;
            err_reg    <= 1'b0;
            valid_reg  <= 1'b0;
            letter_reg <= '0;
            last_reg   <= 1'b0;
            error_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rem_reg    <= rem_next;
            idx_reg    <= idx_next;
            phase_reg  <= phase_next;
            err_reg    <= err_next;
            valid_reg  <= valid_next;
            letter_reg <= letter_next;
            last_reg   <= last_next;
            error_reg  <= error_next;
        end
    end

`ifndef SYNTH
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && error_reg |-> last_reg && (letter_reg == LETTER_NONE))
        else $error("error result without last or with a letter");

    a_letter_legal: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !error_reg |-> (letter_reg == LETTER_M) || (letter_reg == LETTER_D) ||
            (letter_reg == LETTER_C) || (letter_reg == LETTER_L) ||
            (letter_reg == LETTER_X) || (letter_reg == LETTER_V) ||
            (letter_reg == LETTER_I))
        else $error("result letter is not a numeral letter");

    a_pair_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (state_reg == ST_BUSY) && entry.pair && fits)
        else $error("second letter pending outside a subtractive pair");

    a_remainder_falls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUSY) && !accept |=> rem_reg <= $past(rem_reg))
        else $error("remainder grew during a conversion");
`endif

endmodule
